// ----- design/cpbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbe_pkg
// shared types, register indexes and color constants of the pixel expander
// ----------------------------------------------------------------------------
package cpbe_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int PIX_IDX_W  = 3;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_CONTROL = 1'b1;

    // color select / mode control bits
    localparam int CS_PALETTE_BIT = 5;
    localparam int CS_HIRES_BIT   = 7;
    localparam int MC_PLAIN_BIT   = 7;

    localparam logic [COLOR_W-1:0] COLOR_WHITE      = 4'd15;
    localparam logic [COLOR_W-1:0] COLOR_HILITE_PAL = 4'd10;
    localparam logic [COLOR_W-1:0] COLOR_HILITE_STD = 4'd11;

    localparam logic [PIX_IDX_W-1:0] LAST_IDX_2BPP = 3'd3;
    localparam logic [PIX_IDX_W-1:0] LAST_IDX_1BPP = 3'd7;

    typedef enum logic [1:0] {
        MODE_2BPP,
        MODE_1BPP_PLAIN,
        MODE_1BPP_HILITE
    } mode_t;

    // one classified byte, handed from front to back
    typedef struct packed {
        mode_t               mode;
        logic [BYTE_W-1:0]   data;
        logic [COLOR_W-1:0]  bg;
        logic [COLOR_W-1:0]  fg;
        logic                pal_hi;
    } desc_t;

    // four-color lookup for the 2bpp mode
    function automatic logic [COLOR_W-1:0] lut_2bpp(
        input logic               pal_hi,
        input logic [1:0]         pix,
        input logic [COLOR_W-1:0] bg
    );
        logic [COLOR_W-1:0] c;
        unique case (pix)
            2'd0:    c = bg;
            2'd1:    c = pal_hi ? 4'd11 : 4'd2;
            2'd2:    c = pal_hi ? 4'd13 : 4'd4;
            default: c = pal_hi ? 4'd15 : 4'd6;
        endcase
        return c;
    endfunction

endpackage

// ----- design/cga_pixel_byte_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cga_pixel_byte_expander
// expands one video memory byte into a run of 4-bit palette indices
// ----------------------------------------------------------------------------
// usage:
//  - s_ channel takes one video byte per beat (s_pixel_byte)
//  - m_ channel gives one pixel per beat: m_color_index, and m_last_pixel on
//    the final pixel of the byte (4 pixels in 2bpp mode, 8 in 1bpp modes)
//  - cfg_we/cfg_index/cfg_wdata write color select (index 0) and mode
//    control (index 1); write them only while the block is idle
//  - path: front register, queue, serializer byte register, output register
//  - throughput: one pixel per cycle from the serializer while the receiver
//    does not stall and a byte is ready in the queue
//  - the input side keeps accepting while a byte is being serialized: a
//    front register and a two-entry queue hold up to three more bytes
//  - when the receiver stalls the output register holds its beat and the
//    serializer waits; the queue then fills and s_ready drops
//  - reset (aresetn low, synchronous) clears both config registers to zero,
//    empties the queue and drops m_valid
// ----------------------------------------------------------------------------
module cga_pixel_byte_expander (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cpbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cpbe_pkg::BYTE_W-1:0]     s_pixel_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cpbe_pkg::COLOR_W-1:0]    m_color_index,
    output logic                            m_last_pixel
);
    import cpbe_pkg::*;

    // front -> queue
    logic  f_valid;
    logic  f_ready;
    desc_t f_desc;

    // queue -> back
    logic  q_valid;
    logic  q_ready;
    desc_t q_desc;

    // config registers, intake and mode decode
    cpbe_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_byte (s_pixel_byte),
        .f_valid      (f_valid),
        .f_ready      (f_ready),
        .f_desc       (f_desc)
    );

    // decouples intake from serialization
    cpbe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_desc   (f_desc),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_desc  (q_desc)
    );

    // one pixel per beat, next byte loaded on the last pixel
    cpbe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_desc        (q_desc),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_color_index (m_color_index),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

// ----- design/cpbe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbe_front
// config registers, byte intake and mode classification
// ----------------------------------------------------------------------------
module cpbe_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cpbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cpbe_pkg::BYTE_W-1:0]     s_pixel_byte,
    output logic                            f_valid,
    input  logic                            f_ready,
    output cpbe_pkg::desc_t                 f_desc
);
    import cpbe_pkg::*;

    logic [CFG_DATA_W-1:0] color_select_reg;
    logic [CFG_DATA_W-1:0] mode_control_reg;
    logic                  valid_reg;
    desc_t                 desc_reg;
    desc_t                 desc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_select_reg <= '0;
            mode_control_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_COLOR_SELECT: color_select_reg <= cfg_wdata;
                CFG_MODE_CONTROL: mode_control_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        desc_next.data   = s_pixel_byte;
        desc_next.bg     = {color_select_reg[4], color_select_reg[2:0]};
        desc_next.pal_hi = color_select_reg[CS_PALETTE_BIT];
        if (!color_select_reg[CS_HIRES_BIT]) begin
            desc_next.mode = MODE_2BPP;
            desc_next.fg   = COLOR_WHITE;
        end else if (mode_control_reg[MC_PLAIN_BIT]) begin
            desc_next.mode = MODE_1BPP_PLAIN;
            desc_next.fg   = COLOR_WHITE;
        end else begin
            desc_next.mode = MODE_1BPP_HILITE;
            // leading data bit picks the highlight foreground
            if (s_pixel_byte[BYTE_W-1])
                desc_next.fg = color_select_reg[CS_PALETTE_BIT] ? COLOR_HILITE_PAL
                                                                : COLOR_HILITE_STD;
            else
                desc_next.fg = COLOR_WHITE;
        end
    end

    assign s_ready = !valid_reg || f_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            desc_reg <= desc_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_desc  = desc_reg;

endmodule

// ----- design/cpbe_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbe_queue
// two-entry descriptor queue between front and back
// ----------------------------------------------------------------------------
module cpbe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  cpbe_pkg::desc_t in_desc,
    output logic            out_valid,
    input  logic            out_ready,
    output cpbe_pkg::desc_t out_desc
);
    import cpbe_pkg::*;

    desc_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_desc  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_desc;
        end
    end

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ----- design/cpbe_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbe_back
// pixel serializer: one pixel per cycle while the receiver does not stall, into the output register
// ----------------------------------------------------------------------------
module cpbe_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  cpbe_pkg::desc_t                q_desc,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cpbe_pkg::COLOR_W-1:0]   m_color_index,
    output logic                           m_last_pixel
);
    import cpbe_pkg::*;

    logic                 busy_reg;
    desc_t                cur_reg;
    logic [PIX_IDX_W-1:0] idx_reg;
    logic                 m_valid_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic                 last_reg;

    logic                 adv;
    logic                 emit;
    logic                 is_last;
    logic                 pop;
    logic [COLOR_W-1:0]   color_next;
    logic [BYTE_W-1:0]    data_next;

    assign adv  = !m_valid_reg || m_ready;
    assign emit = busy_reg && adv;
    assign is_last = (cur_reg.mode == MODE_2BPP) ? (idx_reg == LAST_IDX_2BPP)
                                                 : (idx_reg == LAST_IDX_1BPP);
    assign pop     = q_valid && (!busy_reg || (emit && is_last));
    assign q_ready = !busy_reg || (emit && is_last);

    // current pixel always sits at the top of the shifting data byte
    always_comb begin
        unique case (cur_reg.mode)
            MODE_2BPP: begin
                color_next = lut_2bpp(cur_reg.pal_hi, cur_reg.data[7:6], cur_reg.bg);
                data_next  = {cur_reg.data[5:0], 2'b00};
            end
            MODE_1BPP_PLAIN: begin
                color_next = cur_reg.data[7] ? cur_reg.fg : cur_reg.bg;
                data_next  = {cur_reg.data[6:0], 1'b0};
            end
            MODE_1BPP_HILITE: begin
                // leading pixel is always background, its bit only picks fg
                if (idx_reg == '0)
                    color_next = cur_reg.bg;
                else
                    color_next = cur_reg.data[7] ? cur_reg.fg : cur_reg.bg;
                data_next = {cur_reg.data[6:0], 1'b0};
            end
            default: begin
                color_next = cur_reg.bg;
                data_next  = cur_reg.data;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (pop) begin
            busy_reg <= 1'b1;
        end else if (emit && is_last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_desc;
            idx_reg <= '0;
        end else if (emit) begin
            cur_reg.data <= data_next;
            idx_reg      <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            color_reg <= color_next;
            last_reg  <= is_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_color_index = color_reg;
    assign m_last_pixel  = last_reg;

    // a new byte is only loaded when the serializer is free or finishing
    a_pop_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!busy_reg || (emit && is_last)))
        else $error("byte loaded while serializer busy");

    // 2bpp bytes never run past their fourth pixel
    a_2bpp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cur_reg.mode == MODE_2BPP) |-> (idx_reg <= LAST_IDX_2BPP))
        else $error("2bpp pixel index overrun");

    // finishing a byte with nothing queued leaves the serializer idle
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && is_last && !q_valid) |=> !busy_reg)
        else $error("serializer stayed busy after last pixel");

endmodule

// ----- test/tb_cga_pixel_byte_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cga_pixel_byte_expander
// self-checking bench for the video byte to palette index expander
// ----------------------------------------------------------------------------
// every accepted video byte is expanded on the bench side into the pixel
// beats it must produce under the current color select / mode control
// setting; each pixel beat leaving the block is checked in order against
// that list. directed bytes cover each display mode and its corner cases,
// then random phases reprogram the registers while idle and stream random
// bytes, with bursty input traffic, a stalling receiver and one long
// receiver hold-off that backs the block up into its input
// ----------------------------------------------------------------------------
module tb_cga_pixel_byte_expander;
    import cpbe_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
    localparam int RANDOM_PHASES = 6;
    localparam int BYTES_PER_PHASE = 24;

    // one expected pixel beat
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               is_last;
    } pixel_t;

    // how the receiver side paces m_ready
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_e;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_COLOR_SELECT;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_pixel_byte = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [COLOR_W-1:0]    m_color_index;
    logic                  m_last_pixel;

    // bench copy of the two registers, updated as they are written
    logic [CFG_DATA_W-1:0] color_select_q = '0;
    logic [CFG_DATA_W-1:0] mode_control_q = '0;

    pixel_t pending_pixels[$];
    int     mismatches = 0;

    // sender pacing
    int     burst_left = 0;
    bit     gaps_on    = 1'b1;

    // receiver pacing
    rx_mode_e    rx_mode    = RX_ALWAYS;
    logic [15:0] rx_pattern = 16'hFFFF;
    int          rx_phase   = 0;
    int          hold_req   = 0;
    int          hold_left  = 0;

    int idle_cycles = 0;

    cga_pixel_byte_expander u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_byte  (s_pixel_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_color_index (m_color_index),
        .m_last_pixel  (m_last_pixel)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // pixel prediction
    // ------------------------------------------------------------------------

    // expand one video byte into the pixel beats the block must send
    function automatic void expand_byte(input logic [BYTE_W-1:0] b);
        mode_t              mode;
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic               pal_hi;
        logic [1:0]         pix;
        pixel_t             p;

        // background: select bits 2:0, bit 4 moves up to index bit 3
        bg     = {color_select_q[4], color_select_q[2:0]};
        pal_hi = color_select_q[CS_PALETTE_BIT];

        if (!color_select_q[CS_HIRES_BIT])
            mode = MODE_2BPP;
        else if (mode_control_q[MC_PLAIN_BIT])
            mode = MODE_1BPP_PLAIN;
        else
            mode = MODE_1BPP_HILITE;

        case (mode)
            MODE_2BPP: begin
                // four 2-bit pixels, msb pair first
                for (int k = 0; k < 4; k++) begin
                    pix = b[7 - 2*k -: 2];
                    case (pix)
                        2'd0:    p.color = bg;
                        2'd1:    p.color = pal_hi ? 4'd11 : 4'd2;
                        2'd2:    p.color = pal_hi ? 4'd13 : 4'd4;
                        default: p.color = pal_hi ? 4'd15 : 4'd6;
                    endcase
                    p.is_last = (k == LAST_IDX_2BPP);
                    pending_pixels.push_back(p);
                end
            end
            default: begin
                // plain mode always uses white; highlight picks by byte msb
                if (mode == MODE_1BPP_PLAIN || !b[7])
                    fg = COLOR_WHITE;
                else
                    fg = pal_hi ? COLOR_HILITE_PAL : COLOR_HILITE_STD;
                for (int k = 0; k < 8; k++) begin
                    // highlight mode: the msb only picks the color, its pixel is bg
                    if (b[7 - k] && !(mode == MODE_1BPP_HILITE && k == 0))
                        p.color = fg;
                    else
                        p.color = bg;
                    p.is_last = (k == LAST_IDX_1BPP);
                    pending_pixels.push_back(p);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // inputs only move at rising edges, so the falling edge sees the
    // handshake that the next rising edge will complete
    always @(negedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel beat color %0d last %0b with none expected",
                                          m_color_index, m_last_pixel));
            end else begin
                want = pending_pixels.pop_front();
                if (m_color_index !== want.color)
                    report_mismatch($sformatf("color_index got %0d expected %0d",
                                              m_color_index, want.color));
                if (m_last_pixel !== want.is_last)
                    report_mismatch($sformatf("last_pixel got %0b expected %0b",
                                              m_last_pixel, want.is_last));
            end
        end
    end

    // watchdog: give up when neither side moves a beat for too long
    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: hold-off requests win, otherwise the current pacing mode
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 99) < 65);
                default: begin
                    m_ready  <= rx_pattern[rx_phase % 16];
                    rx_phase <= rx_phase + 1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // sender and phase helpers (all entered and left at a rising edge)
    // ------------------------------------------------------------------------

    // offer one byte, bursts of random length with random gaps in between
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!gaps_on)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(5, 20);
            else
                gap = $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_pixel_byte <= b;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        expand_byte(b);
        @(posedge aclk);
    endtask

    // stop offering and wait for every expected pixel to leave
    task automatic drain;
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write both registers; only called with the block idle
    task automatic load_config(input logic [7:0] cs, input logic [7:0] mc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COLOR_SELECT;
        cfg_wdata <= cs;
        @(posedge aclk);
        cfg_index <= CFG_MODE_CONTROL;
        cfg_wdata <= mc;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        color_select_q = cs;
        mode_control_q = mc;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // registers straight out of reset: 2bpp, black background, low palette
    task automatic test_reset_defaults;
        rx_mode = RX_ALWAYS;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h1B);
        send_byte(8'hE4);
        drain();
    endtask

    // 2bpp: all four pixel values, high palette, ignored select bits
    task automatic test_two_bit;
        rx_mode = RX_RANDOM;
        load_config(8'h3F, 8'h00);   // bg 15, high palette
        send_byte(8'h1B);
        send_byte(8'hE4);
        send_byte(8'h00);
        drain();
        load_config(8'h48, 8'h7F);   // bits 3 and 6 must not reach bg
        send_byte(8'h1B);
        drain();
    endtask

    // plain 1bpp: set bits white, clear bits background
    task automatic test_plain_one_bit;
        rx_mode = RX_ALWAYS;
        load_config(8'h80, 8'h80);
        send_byte(8'hA5);
        send_byte(8'h00);
        drain();
        load_config(8'hFF, 8'hFF);   // everything set, bg equals white
        send_byte(8'h5A);
        send_byte(8'hFF);
        drain();
    endtask

    // highlight 1bpp: first pixel always bg, msb picks the foreground
    task automatic test_highlight_one_bit;
        rx_mode = RX_RANDOM;
        load_config(8'h80, 8'h00);   // msb set gives the standard highlight
        send_byte(8'h80);
        send_byte(8'h7F);
        drain();
        load_config(8'hA0, 8'h7F);   // palette bit set gives the other one
        send_byte(8'hFF);
        send_byte(8'hC1);
        drain();
        load_config(8'hD7, 8'h00);
        send_byte(8'h00);
        send_byte(8'h81);
        drain();
    endtask

    // random settings per phase, each display mode in turn
    task automatic test_random_stream;
        logic [7:0] cs;
        logic [7:0] mc;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            cs = 8'($urandom_range(0, 255));
            mc = 8'($urandom_range(0, 255));
            cs[CS_HIRES_BIT] = (ph % 3) != 0;
            mc[MC_PLAIN_BIT] = (ph % 3) == 1;
            load_config(cs, mc);

            // one phase runs flat out on both sides
            gaps_on = (ph != 1);
            if (ph == 1)
                rx_mode = RX_ALWAYS;
            else if (ph % 2 == 0)
                rx_mode = RX_RANDOM;
            else begin
                rx_pattern = 16'($urandom) | 16'h0101;
                rx_mode    = RX_PATTERN;
            end

            for (int i = 0; i < BYTES_PER_PHASE; i++)
                send_byte(8'($urandom_range(0, 255)));
            drain();
        end
        gaps_on = 1'b1;
    endtask

    // long receiver hold-off while bytes keep coming: input must back up
    task automatic test_backpressure;
        load_config(8'h85, 8'h80);
        rx_mode  = RX_ALWAYS;
        gaps_on  = 1'b0;
        hold_req = 80;
        for (int i = 0; i < 10; i++)
            send_byte(8'($urandom_range(0, 255)));
        drain();
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_two_bit();
        test_plain_one_bit();
        test_highlight_one_bit();
        test_random_stream();
        test_backpressure();

        // let any stray beat show up before the verdict
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- cga_pixel_byte_expander.f -----
design/cpbe_pkg.sv
design/cpbe_front.sv
design/cpbe_queue.sv
design/cpbe_back.sv
design/cga_pixel_byte_expander.sv
test/tb_cga_pixel_byte_expander.sv
